// ----- hw/rtl/ffba_pkg.sv -----
// Shared definitions for the first-fit block allocator.
// Holds the controller state encoding, request mode codes and size-class breaks.
// No dependencies.
`default_nettype none

package ffba_pkg;

  // Width of the size, address, offset and count fields on the stream ports.
  localparam int FIELD_W = 12;

  // Size-class breaks that choose the split threshold.
  localparam int CLASS_BREAK_LOW  = 256;
  localparam int CLASS_BREAK_HIGH = 1024;

  // Request kinds carried on the slave-side tuser.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EVAL = 5'b00010,
    ST_NXEV = 5'b00100,
    ST_WRB  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ffba_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Used for the block header store. No dependencies.
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/first_fit_block_allocator.sv -----
// First-fit block allocator over one byte region held as a chain of block headers.
// The walk evaluates each header on the chain in turn, then adds a write state for a split,
// a merge state when a freed block has a following block, and a write state for a backward
// merge; an oversize allocate skips the walk. One request at a time; the next is accepted
// while the response is presented. Synchronous reset makes the region one free block
// at offset 0, held in flip-flops, so requests are accepted right after reset.
// Depends on ffba_pkg and ffba_ram.
`default_nettype none

module first_fit_block_allocator #(
  parameter int REGION_BYTES = 4096,
  parameter int HEADER_BYTES = 4,
  parameter int MIN_SPLIT    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] req_size, [23:12] addr
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [11:0] block_offset, [23:12] avail_bytes,
                                      // [24] region_empty, [31:25] zero
  output logic        m_axis_tuser    // [0] ok
);
  import ffba_pkg::*;

  localparam int AW = $clog2(REGION_BYTES);
  localparam int CW = (AW + 2 > 12) ? AW + 2 : 13;
  localparam logic [CW-1:0] REGION_C = CW'(REGION_BYTES);
  localparam logic [CW-1:0] HDR_C    = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] FULL_C   = CW'(REGION_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0] SPLIT_C  = CW'(MIN_SPLIT);
  localparam logic [CW-1:0] LOW_C    = CW'(CLASS_BREAK_LOW);
  localparam logic [CW-1:0] HIGH_C   = CW'(CLASS_BREAK_HIGH);

  typedef struct packed {
    logic          used;
    logic [AW-1:0] size;
  } hdr_t;

  state_t              state;
  logic                mode_r;
  logic [FIELD_W-1:0]  req_r;
  logic [FIELD_W-1:0]  addr_r;
  logic [AW-1:0]       o;
  logic [AW-1:0]       avail;
  logic [AW-1:0]       prev_o;
  hdr_t                prev_hdr;
  logic                has_prev;
  logic [AW-1:0]       cur_size;
  logic [AW-1:0]       wb_addr;
  hdr_t                wb_data;
  hdr_t                h0;
  logic                res_ok;
  logic [FIELD_W-1:0]  res_off;
  logic                out_ok;
  logic [FIELD_W-1:0]  out_off;
  logic [FIELD_W-1:0]  out_avail;
  logic                out_empty;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  hdr_t                ram_wdata;
  logic [AW-1:0]       ram_raddr;
  hdr_t                ram_rdata;

  hdr_t                cur;
  logic [CW-1:0]       cur_w, o_w, req_w, addr_w, avail_w, nx_w, rem_w, n_w;
  logic [CW-1:0]       bsize_w, take_w, cost_w, avail_sub, credit, avail_add;
  logic [CW-1:0]       so_w, prev_sum_eval, prev_sum_nx, in_req_w;
  logic                nx_last, fit, match, split, in_reject, out_free, empty_now;

  ffba_ram #(.WIDTH(AW + 1), .DEPTH(REGION_BYTES)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Header under evaluation; header 0 is kept in flip-flops.
  assign cur     = (o == '0) ? h0 : ram_rdata;
  assign cur_w   = CW'(cur.size);
  assign o_w     = CW'(o);
  assign req_w   = CW'(req_r);
  assign addr_w  = CW'(addr_r);
  assign avail_w = CW'(avail);
  assign nx_w    = o_w + HDR_C + cur_w;
  assign nx_last = nx_w >= REGION_C;

  // Allocate: fit test, split decision and count debit.
  assign bsize_w   = (req_w < LOW_C) ? SPLIT_C : ((req_w < HIGH_C) ? LOW_C : HIGH_C);
  assign fit       = !cur.used && (cur_w >= req_w);
  assign rem_w     = cur_w - req_w;
  assign split     = rem_w > (HDR_C + bsize_w);
  assign n_w       = o_w + HDR_C + req_w;
  assign take_w    = split ? req_w : cur_w;
  assign cost_w    = HDR_C + take_w;
  assign avail_sub = (avail_w >= cost_w) ? avail_w - cost_w : '0;

  // Free: address match, count credit and merge sizes.
  assign match         = (o_w < addr_w) && (addr_w < nx_w);
  assign credit        = avail_w + HDR_C + cur_w;
  assign avail_add     = (credit > FULL_C) ? FULL_C : credit;
  assign prev_sum_eval = CW'(prev_hdr.size) + HDR_C + cur_w;
  assign so_w          = ram_rdata.used ? CW'(cur_size)
                                        : CW'(cur_size) + HDR_C + CW'(ram_rdata.size);
  assign prev_sum_nx   = CW'(prev_hdr.size) + HDR_C + so_w;
  assign out_free      = has_prev && !prev_hdr.used;

  // Early reject of an oversize allocate at request time.
  assign in_req_w  = CW'(s_axis_tdata[11:0]);
  assign in_reject = (s_axis_tuser == MODE_ALLOC) &&
                     ((in_req_w >= REGION_C) || (avail_w < HDR_C + in_req_w));

  assign empty_now = !h0.used && ((HDR_C + CW'(h0.size)) >= REGION_C);

  // The walk reads the next header while the current one is evaluated.
  assign ram_raddr = (state == ST_EVAL) ? nx_w[AW-1:0] : '0;

  // Header write port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = o;
    ram_wdata = '0;
    case (state)
      ST_EVAL: begin
        if (mode_r == MODE_ALLOC) begin
          if (fit) begin
            ram_we    = 1'b1;
            ram_wdata = '{used: 1'b1, size: take_w[AW-1:0]};
          end
        end else if (match && cur.used && nx_last) begin
          ram_we    = 1'b1;
          ram_wdata = '{used: 1'b0, size: cur.size};
        end
      end
      ST_NXEV: begin
        ram_we    = 1'b1;
        ram_wdata = '{used: 1'b0, size: so_w[AW-1:0]};
      end
      ST_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = wb_addr;
        ram_wdata = wb_data;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {7'b0, out_empty, out_avail, out_off};
  assign m_axis_tuser  = out_ok;

  // Controller, counters and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      avail         <= AW'(REGION_BYTES - HEADER_BYTES);
      h0            <= '{used: 1'b0, size: AW'(REGION_BYTES - HEADER_BYTES)};
      m_axis_tvalid <= 1'b0;
      has_prev      <= 1'b0;
    end else begin
      if (ram_we && ram_waddr == '0) begin
        h0 <= ram_wdata;
      end
      // The completion state reloads the response register itself.
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mode_r   <= s_axis_tuser;
            req_r    <= s_axis_tdata[11:0];
            addr_r   <= s_axis_tdata[23:12];
            o        <= '0;
            has_prev <= 1'b0;
            res_ok   <= 1'b0;
            res_off  <= '0;
            state    <= in_reject ? ST_DONE : ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (mode_r == MODE_ALLOC) begin
            if (fit) begin
              avail   <= avail_sub[AW-1:0];
              res_ok  <= 1'b1;
              res_off <= FIELD_W'(o_w + HDR_C);
              if (split && n_w < REGION_C) begin
                wb_addr <= n_w[AW-1:0];
                wb_data <= '{used: 1'b0, size: AW'(rem_w - HDR_C)};
                state   <= ST_WRB;
              end else begin
                state <= ST_DONE;
              end
            end else if (nx_last) begin
              state <= ST_DONE;
            end else begin
              o <= nx_w[AW-1:0];
            end
          end else begin
            if (match) begin
              if (cur.used) begin
                avail  <= avail_add[AW-1:0];
                res_ok <= 1'b1;
                if (!nx_last) begin
                  cur_size <= cur.size;
                  state    <= ST_NXEV;
                end else if (out_free) begin
                  wb_addr <= prev_o;
                  wb_data <= '{used: 1'b0, size: prev_sum_eval[AW-1:0]};
                  state   <= ST_WRB;
                end else begin
                  state <= ST_DONE;
                end
              end else begin
                state <= ST_DONE;
              end
            end else if (nx_last) begin
              state <= ST_DONE;
            end else begin
              prev_o   <= o;
              prev_hdr <= cur;
              has_prev <= 1'b1;
              o        <= nx_w[AW-1:0];
            end
          end
        end
        ST_NXEV: begin
          // Forward merge is written now; backward merge follows if needed.
          if (out_free) begin
            wb_addr <= prev_o;
            wb_data <= '{used: 1'b0, size: prev_sum_nx[AW-1:0]};
            state   <= ST_WRB;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_WRB: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_ok        <= res_ok;
            out_off       <= res_off;
            out_avail     <= FIELD_W'(avail);
            out_empty     <= empty_now;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The available count never exceeds a fully free region.
  a_avail_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(avail) <= FULL_C)
    else $error("available count above region capacity");

  // Header writes happen only while a request is being worked on.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state != ST_IDLE && state != ST_DONE))
    else $error("header write outside a request");

  // An oversize allocate is answered without walking the chain.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && in_reject) |=> state == ST_DONE)
    else $error("oversize allocate entered the walk");

  // A completed request leaves the response valid and the controller idle.
  a_complete: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!m_axis_tvalid || m_axis_tready))
      |=> (m_axis_tvalid && state == ST_IDLE))
    else $error("response not presented on completion");

  // A failed request reports a zero offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_ok) |-> out_off == '0)
    else $error("nonzero offset on failure");

endmodule

`default_nettype wire

// ----- tb/first_fit_block_allocator_tb.sv -----
// Self-checking testbench for the first-fit block allocator.
// A scoreboard class predicts each response from its own copy of the header chain.
// Depends on ffba_pkg and the first_fit_block_allocator RTL.

module first_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  localparam int REGION    = 4096;
  localparam int HDR       = 4;
  localparam int MIN_SPL   = 8;
  localparam int FULL_FREE = REGION - HDR;
  localparam int N_RANDOM  = 2000;
  localparam int LIMIT     = 8000000;

  typedef struct packed {
    logic        ok;
    logic [11:0] block_offset;
    logic [11:0] avail_bytes;
    logic        region_empty;
  } alloc_resp_t;

  // Scoreboard: tracks the block chain and the responses still owed by the block.
  class alloc_scoreboard;
    int          blk_size [REGION];
    bit          blk_used [REGION];
    int          avail;
    alloc_resp_t pending [$];
    int          live_blocks [$];
    int          errors;
    int          n_alloc_ok;
    int          n_free_ok;
    int          n_fail;
    int          n_checked;

    function new();
      blk_size[0] = FULL_FREE;
      blk_used[0] = 1'b0;
      avail       = FULL_FREE;
    endfunction

    function bit try_alloc(int req, output int off);
      int o, s, nx, thresh, rem, cost, n;
      bit hit;
      o = 0;
      s = 0;
      hit = 1'b0;
      off = 0;
      if (req >= REGION || avail < HDR + req) return 1'b0;
      if (req < CLASS_BREAK_LOW) thresh = MIN_SPL;
      else if (req < CLASS_BREAK_HIGH) thresh = CLASS_BREAK_LOW;
      else thresh = CLASS_BREAK_HIGH;
      // First-fit walk along the chain.
      while (o < REGION) begin
        s = blk_size[o];
        nx = o + HDR + s;
        if (!blk_used[o] && s >= req) begin
          hit = 1'b1;
          break;
        end
        if (nx >= REGION) break;
        o = nx;
      end
      if (!hit) return 1'b0;
      blk_used[o] = 1'b1;
      rem = s - req;
      // Split off the tail when it is large enough for its size class.
      if (rem > HDR + thresh) begin
        n = o + HDR + req;
        blk_size[o] = req;
        if (n < REGION) begin
          blk_size[n] = rem - HDR;
          blk_used[n] = 1'b0;
        end
      end
      cost = HDR + blk_size[o];
      avail = (avail >= cost) ? avail - cost : 0;
      off = o + HDR;
      return 1'b1;
    endfunction

    function bit try_free(int addr);
      int o, nx, prev, credit;
      bit has_prev, hit;
      o = 0;
      nx = 0;
      prev = 0;
      has_prev = 1'b0;
      hit = 1'b0;
      while (o < REGION) begin
        nx = o + HDR + blk_size[o];
        if (o < addr && addr < nx) begin
          hit = 1'b1;
          break;
        end
        if (nx >= REGION) break;
        prev = o;
        has_prev = 1'b1;
        o = nx;
      end
      if (!hit || !blk_used[o]) return 1'b0;
      blk_used[o] = 1'b0;
      credit = avail + HDR + blk_size[o];
      avail = (credit > FULL_FREE) ? FULL_FREE : credit;
      foreach (live_blocks[i]) begin
        if (live_blocks[i] == o + HDR) begin
          live_blocks.delete(i);
          break;
        end
      end
      // Coalesce forward, then backward.
      if (nx < REGION && !blk_used[nx]) blk_size[o] += HDR + blk_size[nx];
      if (has_prev && !blk_used[prev]) blk_size[prev] += HDR + blk_size[o];
      return 1'b1;
    endfunction

    // Records one accepted request and queues the response it should produce.
    function void note_request(logic mode, int req, int addr);
      alloc_resp_t r;
      int off;
      off = 0;
      if (mode == MODE_ALLOC) begin
        r.ok = try_alloc(req, off);
        if (r.ok) begin
          live_blocks.push_back(off);
          n_alloc_ok++;
        end
      end else begin
        r.ok = try_free(addr);
        if (r.ok) n_free_ok++;
      end
      if (!r.ok) n_fail++;
      r.block_offset = off[11:0];
      r.avail_bytes  = avail[11:0];
      r.region_empty = !blk_used[0] && (HDR + blk_size[0] >= REGION);
      pending.push_back(r);
    endfunction

    task report(string what, int got, int exp);
      $display("mismatch on response %0d: %s got %0d expected %0d", n_checked, what, got, exp);
      errors++;
    endtask

    // Compares one accepted response against the oldest queued prediction.
    task check_response(alloc_resp_t got);
      alloc_resp_t exp;
      if (pending.size() == 0) begin
        report("unexpected response, ok", got.ok, 0);
      end else begin
        exp = pending.pop_front();
        if (got.ok !== exp.ok) report("ok", got.ok, exp.ok);
        if (got.block_offset !== exp.block_offset)
          report("block_offset", got.block_offset, exp.block_offset);
        if (got.avail_bytes !== exp.avail_bytes)
          report("avail_bytes", got.avail_bytes, exp.avail_bytes);
        if (got.region_empty !== exp.region_empty)
          report("region_empty", got.region_empty, exp.region_empty);
      end
      n_checked++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  alloc_scoreboard sb;
  int              cycle_count;

  first_fit_block_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sends one request after a random gap; valid stays high across zero gaps.
  task send_request(logic mode, int req, int addr);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {addr[11:0], req[11:0]};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(mode, req, addr);
  endtask

  task wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Allocation sizes lean small so the chain grows long, with occasional big ones.
  function int random_size();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 4095);
      1: return $urandom_range(256, 1100);
      default: return $urandom_range(0, 64);
    endcase
  endfunction

  // Response side: random stall per response, then take it.
  initial begin
    alloc_resp_t got;
    int stall;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.ok           = m_axis_tuser;
      got.block_offset = m_axis_tdata[11:0];
      got.avail_bytes  = m_axis_tdata[23:12];
      got.region_empty = m_axis_tdata[24];
      sb.check_response(got);
    end
  end

  initial begin
    int pick, base;
    sb = new();
    cycle_count = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_ALLOC;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, size classes, and the failure cases.
    send_request(MODE_FREE, 0, 0);        // address on a header offset
    send_request(MODE_ALLOC, 4095, 0);    // oversize
    send_request(MODE_ALLOC, 4093, 0);    // exceeds the available count
    send_request(MODE_ALLOC, 0, 4095);    // zero request
    send_request(MODE_FREE, 0, 4);        // the empty block cannot be freed
    send_request(MODE_ALLOC, 255, 0);
    send_request(MODE_ALLOC, 256, 0);
    send_request(MODE_ALLOC, 1023, 0);
    send_request(MODE_ALLOC, 1024, 0);
    send_request(MODE_FREE, 4095, 12);    // inside the 255-byte block
    send_request(MODE_FREE, 4095, 12);    // double free
    send_request(MODE_FREE, 0, 4095);     // in the trailing free block or past it
    send_request(MODE_FREE, 0, 300);      // merges backward with the freed block
    send_request(MODE_ALLOC, 2000, 0);    // no fitting block
    send_request(MODE_FREE, 0, 1600);
    send_request(MODE_FREE, 0, 2700);
    send_request(MODE_ALLOC, 4092, 0);    // whole region
    send_request(MODE_FREE, 0, 4);        // again on the zero-size block, which cannot be freed
    wait_drained();

    // Random mix: mostly allocates and frees of live blocks, some noise addresses.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) wait_drained();
      pick = $urandom_range(0, 19);
      if (pick < 9 || sb.live_blocks.size() == 0 && pick < 17) begin
        send_request(MODE_ALLOC, random_size(), $urandom_range(0, 4095));
      end else if (pick < 17) begin
        base = sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)];
        send_request(MODE_FREE, $urandom_range(0, 4095),
                     ($urandom_range(0, 1) == 0) ? base : base + $urandom_range(0, 3));
      end else begin
        send_request(MODE_FREE, $urandom_range(0, 4095), $urandom_range(0, 4095));
      end
    end
    wait_drained();
    repeat (1100) @(posedge clk);

    $display("covered %0d responses: %0d allocations, %0d frees succeeded, %0d rejected",
             sb.n_checked, sb.n_alloc_ok, sb.n_free_ok, sb.n_fail);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d responses missing", sb.errors, sb.pending.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
